// ===== rtl/core/spt_pkg.sv =====
// shared types, constants and byte classification for the tokenizer
`default_nettype none

package spt_pkg;

  localparam int unsigned MaxTok = 3;
  localparam int unsigned TokIdxW = 2;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = 2;
  localparam int unsigned QCntW = 3;
  localparam logic [15:0] LenMax = 16'hFFFF;

  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [3:0] {
    KindSymbol = 4'd0,
    KindLBrace = 4'd1,
    KindRBrace = 4'd2,
    KindLBrack = 4'd3,
    KindRBrack = 4'd4,
    KindLParen = 4'd5,
    KindRParen = 4'd6,
    KindPlus   = 4'd7,
    KindMinus  = 4'd8,
    KindTilde  = 4'd9,
    KindChar   = 4'd10,
    KindEnd    = 4'd11
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] start;
    logic [15:0] len;
  } tok_t;

  // tokens of one input word, packed from slot 0 up
  typedef struct packed {
    tok_t [MaxTok-1:0]  tok;
    logic [TokIdxW-1:0] cnt;
  } rec_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic continues_symbol(input logic [7:0] b);
    return is_letter(b) || is_digit(b) || (b == ChUnder);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChCr) || (b == ChLf);
  endfunction

  function automatic kind_e punct_kind(input logic [7:0] b);
    kind_e k;
    case (b)
      ChLBrace: k = KindLBrace;
      ChRBrace: k = KindRBrace;
      ChLBrack: k = KindLBrack;
      ChRBrack: k = KindRBrack;
      ChLParen: k = KindLParen;
      ChRParen: k = KindRParen;
      ChPlus:   k = KindPlus;
      ChMinus:  k = KindMinus;
      ChTilde:  k = KindTilde;
      default:  k = KindChar;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/spt_front.sv =====
// front end: classifies each byte, tracks the open symbol, builds token records
`default_nettype none

module spt_front #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic               last_i,
  input  wire logic               full_i,
  output logic                    rec_valid_o,
  output spt_pkg::rec_t           rec_o
);

  logic                   open_q, open_d;
  logic [15:0]            start_q, start_d;
  logic [15:0]            len_q, len_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;

  logic [OFFSET_BITS-1:0] pos_n;
  logic [OFFSET_BITS+15:0] pos_ext, pos_n_ext;
  logic [15:0]            pos16, pos_n16;
  logic                   accept;

  assign accept    = push_i && !full_i;
  assign pos_n     = pos_q + OFFSET_BITS'(1);
  assign pos_ext   = {16'd0, pos_q};
  assign pos_n_ext = {16'd0, pos_n};
  assign pos16     = pos_ext[15:0];
  assign pos_n16   = pos_n_ext[15:0];

  always_comb begin
    spt_pkg::rec_t               rec;
    logic [spt_pkg::TokIdxW-1:0] n;
    rec     = '0;
    n       = '0;
    open_d  = open_q;
    start_d = start_q;
    len_d   = len_q;
    pos_d   = pos_n;

    if (open_q && spt_pkg::continues_symbol(byte_i)) begin
      if (len_q != spt_pkg::LenMax) begin
        len_d = len_q + 16'd1;
      end
    end else begin
      if (open_q) begin
        rec.tok[n] = '{kind: spt_pkg::KindSymbol, start: start_q, len: len_q};
        n          = n + 1'b1;
        open_d     = 1'b0;
      end
      if (spt_pkg::is_letter(byte_i)) begin
        open_d  = 1'b1;
        start_d = pos16;
        len_d   = 16'd1;
      end else if (!spt_pkg::is_space(byte_i)) begin
        rec.tok[n] = '{kind: spt_pkg::punct_kind(byte_i), start: pos16, len: 16'd1};
        n          = n + 1'b1;
      end
    end

    if (last_i) begin
      if (open_d) begin
        rec.tok[n] = '{kind: spt_pkg::KindSymbol, start: start_d, len: len_d};
        n          = n + 1'b1;
      end
      rec.tok[n] = '{kind: spt_pkg::KindEnd, start: pos_n16, len: 16'd0};
      n          = n + 1'b1;
      open_d     = 1'b0;
      start_d    = '0;
      len_d      = '0;
      pos_d      = '0;
    end

    rec.cnt     = n;
    rec_o       = rec;
    rec_valid_o = accept && (n != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      start_q <= '0;
      len_q   <= '0;
      pos_q   <= '0;
    end else if (accept) begin
      open_q  <= open_d;
      start_q <= start_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/spt_queue.sv =====
// short record queue between front and back end
`default_nettype none

module spt_queue (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    wr_i,
  input  wire spt_pkg::rec_t wdata_i,
  output logic         full_o,
  input  wire logic    rd_i,
  output spt_pkg::rec_t rdata_o,
  output logic         empty_o
);

  spt_pkg::rec_t mem_q [spt_pkg::QDepth];

  logic [spt_pkg::QPtrW-1:0] wptr_q, rptr_q;
  logic [spt_pkg::QCntW-1:0] cnt_q;
  logic                      do_wr, do_rd;

  assign full_o  = cnt_q == spt_pkg::QCntW'(spt_pkg::QDepth);
  assign empty_o = cnt_q == '0;
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= spt_pkg::QCntW'(spt_pkg::QDepth))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || full_o) |-> (wptr_q == rptr_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/core/spt_back.sv =====
// back end: hands out the tokens of each record one word at a time
`default_nettype none

module spt_back (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_empty_i,
  input  wire spt_pkg::rec_t q_head_i,
  output logic         q_pop_o,
  output logic         empty_o,
  input  wire logic    pop_i,
  output logic [3:0]   token_kind_o,
  output logic [15:0]  start_offset_o,
  output logic [15:0]  token_length_o,
  output logic         last_of_run_o
);

  logic [spt_pkg::TokIdxW-1:0] idx_q;
  logic                        is_last;
  logic                        take;
  spt_pkg::tok_t               cur;

  assign cur            = q_head_i.tok[idx_q];
  assign is_last        = idx_q == (q_head_i.cnt - 1'b1);
  assign take           = pop_i && !q_empty_i;
  assign empty_o        = q_empty_i;
  assign q_pop_o        = take && is_last;
  assign token_kind_o   = cur.kind;
  assign start_offset_o = cur.start;
  assign token_length_o = cur.len;
  assign last_of_run_o  = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      idx_q <= is_last ? '0 : idx_q + 1'b1;
    end
  end

  a_idx_in_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> (idx_q < q_head_i.cnt))
    else $error("token index past end of record");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty_i |-> (idx_q == '0))
    else $error("token index left open with no record");

  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty_i && cur.kind == spt_pkg::KindEnd) |-> last_of_run_o)
    else $error("end token not last of its run");

endmodule

`default_nettype wire

// ===== rtl/core/symbol_punctuation_tokenizer.sv =====
// top level of the symbol and punctuation tokenizer
// Input side is a queue write port: a byte word is taken on a rising edge
// with push high and full low, one word per cycle when not full.
// Output side is a queue read port: while empty is low the oldest token is
// on the result ports; it is taken on a rising edge with pop high.
// Each byte gives zero to three tokens; last_of_run marks the final token
// of a byte. Bytes that give none (a symbol's start or continuation, or
// whitespace with no symbol open) pass with no output.
// A byte's tokens are queued when it is taken. Throughput: one byte per
// cycle in when not full, one token per cycle out while not empty and pop
// is high; the four-record queue between the classifier and the output
// sequencer absorbs bursts, and full rises only when it holds four records.
// A stalled receiver keeps the current token steady; input continues until
// the queue fills. Reset clears the symbol state, the offset counter and the
// queue, so the first byte after reset is at offset 0.
`default_nettype none

module symbol_punctuation_tokenizer #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic        end_of_input_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       token_kind_o,
  output logic [15:0]      start_offset_o,
  output logic [15:0]      token_length_o,
  output logic             last_of_run_o
);

  logic          rec_valid;
  spt_pkg::rec_t rec;
  spt_pkg::rec_t head;
  logic          q_full, q_empty, q_pop;

  assign full = q_full;

  spt_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .byte_i      (byte_value_i),
    .last_i      (end_of_input_i),
    .full_i      (q_full),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  spt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (rec_valid),
    .wdata_i (rec),
    .full_o  (q_full),
    .rd_i    (q_pop),
    .rdata_o (head),
    .empty_o (q_empty)
  );

  spt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_head_i       (head),
    .q_pop_o        (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the symbol and punctuation tokenizer
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    spt_pkg::kind_e kind;
    logic [15:0]    start;
    logic [15:0]    len;
    logic           last;
  } token_t;

  typedef struct {
    logic [7:0] b;
    logic       eoi;
    bit         typed;
    int         n;
    token_t     tok [3];
  } dir_row_t;

  localparam token_t NoTok = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  byte_value_i = '0;
  logic        end_of_input_i = 1'b0;
  wire         full;
  wire         empty;
  wire  [3:0]  token_kind_o;
  wire  [15:0] start_offset_o;
  wire  [15:0] token_length_o;
  wire         last_of_run_o;

  // predictor state
  logic        sym_open = 1'b0;
  logic [15:0] sym_start = '0;
  logic [15:0] sym_len = '0;
  logic [15:0] byte_pos = '0;

  token_t   expected_tokens [$];
  dir_row_t dir_rows [$];
  int       row_sel = -1;
  int       errors = 0;
  int       bytes_taken = 0;
  int       tokens_checked = 0;
  int       end_tokens = 0;
  int       full_stalls = 0;
  int       burst_left = 0;
  int       hold_asks = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  int       rx_cycle = 0;

  symbol_punctuation_tokenizer #(
    .OFFSET_BITS(16)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .byte_value_i   (byte_value_i),
    .end_of_input_i (end_of_input_i),
    .empty          (empty),
    .pop            (pop),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d tokens outstanding", expected_tokens.size());
    $display("symbol_punctuation_tokenizer verification failed");
    $finish;
  end

  function automatic bit letter_byte(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit word_byte(input logic [7:0] b);
    return letter_byte(b) || (b >= "0" && b <= "9") || b == spt_pkg::ChUnder;
  endfunction

  function automatic bit blank_byte(input logic [7:0] b);
    return b == spt_pkg::ChSpace || b == spt_pkg::ChTab || b == spt_pkg::ChCr ||
           b == spt_pkg::ChLf;
  endfunction

  function automatic spt_pkg::kind_e single_kind(input logic [7:0] b);
    case (b)
      spt_pkg::ChLBrace: return spt_pkg::KindLBrace;
      spt_pkg::ChRBrace: return spt_pkg::KindRBrace;
      spt_pkg::ChLBrack: return spt_pkg::KindLBrack;
      spt_pkg::ChRBrack: return spt_pkg::KindRBrack;
      spt_pkg::ChLParen: return spt_pkg::KindLParen;
      spt_pkg::ChRParen: return spt_pkg::KindRParen;
      spt_pkg::ChPlus:   return spt_pkg::KindPlus;
      spt_pkg::ChMinus:  return spt_pkg::KindMinus;
      spt_pkg::ChTilde:  return spt_pkg::KindTilde;
      default:           return spt_pkg::KindChar;
    endcase
  endfunction

  function automatic token_t tk(input spt_pkg::kind_e k, input logic [15:0] s,
                                input logic [15:0] l, input logic last);
    token_t t;
    t.kind = k;
    t.start = s;
    t.len = l;
    t.last = last;
    return t;
  endfunction

  function automatic dir_row_t mk_row(input logic [7:0] b, input logic eoi, input bit typed,
                                      input int n, input token_t t0, input token_t t1,
                                      input token_t t2);
    dir_row_t r;
    r.b = b;
    r.eoi = eoi;
    r.typed = typed;
    r.n = n;
    r.tok[0] = t0;
    r.tok[1] = t1;
    r.tok[2] = t2;
    return r;
  endfunction

  // tokens caused by one word, updating the tokenizer state
  task automatic tokenize_byte(input logic [7:0] b, input logic eoi, output int n,
                               output token_t t [3]);
    logic [15:0] at;
    n = 0;
    at = byte_pos;
    t[0] = NoTok;
    t[1] = NoTok;
    t[2] = NoTok;
    if (sym_open && word_byte(b)) begin
      if (sym_len != spt_pkg::LenMax) sym_len = sym_len + 16'd1;
    end else begin
      if (sym_open) begin
        t[n] = tk(spt_pkg::KindSymbol, sym_start, sym_len, 1'b0);
        n++;
        sym_open = 1'b0;
      end
      if (letter_byte(b)) begin
        sym_open = 1'b1;
        sym_start = at;
        sym_len = 16'd1;
      end else if (!blank_byte(b)) begin
        t[n] = tk(single_kind(b), at, 16'd1, 1'b0);
        n++;
      end
    end
    at = at + 16'd1;
    byte_pos = at;
    if (eoi) begin
      if (sym_open) begin
        t[n] = tk(spt_pkg::KindSymbol, sym_start, sym_len, 1'b0);
        n++;
      end
      t[n] = tk(spt_pkg::KindEnd, at, 16'd0, 1'b0);
      n++;
      sym_open = 1'b0;
      sym_start = '0;
      sym_len = '0;
      byte_pos = '0;
    end
    if (n > 0) t[n-1].last = 1'b1;
  endtask

  task automatic flag_field(input string name, input logic [15:0] want, input logic [15:0] got);
    errors++;
    if (errors <= 40) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // input monitor, prediction, output checking and the receiver
  always @(posedge clk_i) begin
    int n;
    token_t pred [3];
    token_t want;
    if (rst_ni) begin
      if (push && full) full_stalls++;
      if (push && !full) begin
        tokenize_byte(byte_value_i, end_of_input_i, n, pred);
        bytes_taken++;
        if (row_sel >= 0 && dir_rows[row_sel].typed) begin
          n = dir_rows[row_sel].n;
          for (int i = 0; i < 3; i++) pred[i] = dir_rows[row_sel].tok[i];
        end
        for (int i = 0; i < n; i++) expected_tokens.push_back(pred[i]);
      end
      if (pop && !empty) begin
        if (expected_tokens.size() == 0) begin
          errors++;
          if (errors <= 40) begin
            $display("%0t: unexpected word, expected none, actual kind %0d start %0d len %0d",
                     $time, token_kind_o, start_offset_o, token_length_o);
          end
        end else begin
          want = expected_tokens.pop_front();
          tokens_checked++;
          if (want.kind == spt_pkg::KindEnd) end_tokens++;
          if (token_kind_o !== want.kind) flag_field("token_kind", 16'(want.kind),
                                                     16'(token_kind_o));
          if (start_offset_o !== want.start) flag_field("start_offset", want.start,
                                                         start_offset_o);
          if (token_length_o !== want.len) flag_field("token_length", want.len,
                                                       token_length_o);
          if (last_of_run_o !== want.last) flag_field("last_of_run", 16'(want.last),
                                                       16'(last_of_run_o));
        end
      end
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = 80;
      end
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case ((rx_cycle / 64) % 3)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 3) != 0);
          default: pop <= ((rx_cycle % 5) != 2);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eoi, input int row);
    int gap;
    gap = 0;
    if (hold_left == 0) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    byte_value_i <= b;
    end_of_input_i <= eoi;
    row_sel <= row;
    do @(posedge clk_i); while (full);
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return spt_pkg::ChUnder;
  endfunction

  function automatic logic [7:0] random_char();
    logic [7:0] blanks [4];
    logic [7:0] singles [9];
    int r;
    blanks = '{spt_pkg::ChSpace, spt_pkg::ChTab, spt_pkg::ChCr, spt_pkg::ChLf};
    singles = '{spt_pkg::ChLBrace, spt_pkg::ChRBrace, spt_pkg::ChLBrack, spt_pkg::ChRBrack,
                spt_pkg::ChLParen, spt_pkg::ChRParen, spt_pkg::ChPlus, spt_pkg::ChMinus,
                spt_pkg::ChTilde};
    r = $urandom_range(0, 19);
    if (r < 10) return word_char();
    if (r < 12) return blanks[$urandom_range(0, 3)];
    if (r < 17) return singles[$urandom_range(0, 8)];
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    dir_rows.push_back(mk_row("A", 1'b0, 1'b1, 0, NoTok, NoTok, NoTok));
    dir_rows.push_back(mk_row("z", 1'b0, 1'b1, 0, NoTok, NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChUnder, 1'b0, 1'b1, 0, NoTok, NoTok, NoTok));
    dir_rows.push_back(mk_row("9", 1'b0, 1'b1, 0, NoTok, NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChSpace, 1'b0, 1'b1, 1,
                              tk(spt_pkg::KindSymbol, 16'd0, 16'd4, 1'b1), NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChLBrace, 1'b0, 1'b1, 1,
                              tk(spt_pkg::KindLBrace, 16'd5, 16'd1, 1'b1), NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChRBrace, 1'b0, 1'b1, 1,
                              tk(spt_pkg::KindRBrace, 16'd6, 16'd1, 1'b1), NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChLBrack, 1'b0, 1'b1, 1,
                              tk(spt_pkg::KindLBrack, 16'd7, 16'd1, 1'b1), NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChRBrack, 1'b0, 1'b1, 1,
                              tk(spt_pkg::KindRBrack, 16'd8, 16'd1, 1'b1), NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChLParen, 1'b0, 1'b1, 1,
                              tk(spt_pkg::KindLParen, 16'd9, 16'd1, 1'b1), NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChRParen, 1'b0, 1'b1, 1,
                              tk(spt_pkg::KindRParen, 16'd10, 16'd1, 1'b1), NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChPlus, 1'b0, 1'b1, 1,
                              tk(spt_pkg::KindPlus, 16'd11, 16'd1, 1'b1), NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChMinus, 1'b0, 1'b1, 1,
                              tk(spt_pkg::KindMinus, 16'd12, 16'd1, 1'b1), NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChTilde, 1'b0, 1'b1, 1,
                              tk(spt_pkg::KindTilde, 16'd13, 16'd1, 1'b1), NoTok, NoTok));
    dir_rows.push_back(mk_row(8'h00, 1'b0, 1'b1, 1,
                              tk(spt_pkg::KindChar, 16'd14, 16'd1, 1'b1), NoTok, NoTok));
    dir_rows.push_back(mk_row(8'hFF, 1'b0, 1'b1, 1,
                              tk(spt_pkg::KindChar, 16'd15, 16'd1, 1'b1), NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChTab, 1'b0, 1'b0, 0, NoTok, NoTok, NoTok));
    dir_rows.push_back(mk_row("Z", 1'b0, 1'b0, 0, NoTok, NoTok, NoTok));
    dir_rows.push_back(mk_row("0", 1'b0, 1'b0, 0, NoTok, NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChCr, 1'b0, 1'b0, 0, NoTok, NoTok, NoTok));
    dir_rows.push_back(mk_row("q", 1'b0, 1'b0, 0, NoTok, NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChRParen, 1'b0, 1'b0, 0, NoTok, NoTok, NoTok));
    dir_rows.push_back(mk_row("a", 1'b1, 1'b1, 2,
                              tk(spt_pkg::KindSymbol, 16'd22, 16'd1, 1'b0),
                              tk(spt_pkg::KindEnd, 16'd23, 16'd0, 1'b1), NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChUnder, 1'b0, 1'b1, 1,
                              tk(spt_pkg::KindChar, 16'd0, 16'd1, 1'b1), NoTok, NoTok));
    dir_rows.push_back(mk_row(spt_pkg::ChMinus, 1'b1, 1'b1, 2,
                              tk(spt_pkg::KindMinus, 16'd1, 16'd1, 1'b0),
                              tk(spt_pkg::KindEnd, 16'd2, 16'd0, 1'b1), NoTok));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < dir_rows.size(); i++) begin
      send_byte(dir_rows[i].b, dir_rows[i].eoi, i);
    end
    for (int i = 0; i < 110; i++) begin
      if (i == 40) hold_asks++;
      send_byte(random_char(), $urandom_range(0, 24) == 0, -1);
    end
    for (int i = 0; i < 95; i++) begin
      if (i == 50) hold_asks++;
      send_byte(random_char(), $urandom_range(0, 24) == 0, -1);
    end
    send_byte(spt_pkg::ChSpace, 1'b1, -1);
    push <= 1'b0;

    @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d words in (%0d directed, rest random in bursts), %0d tokens checked",
             bytes_taken, dir_rows.size(), tokens_checked);
    $display("%0d end tokens, %0d cycles with input held off by full", end_tokens,
             full_stalls);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("symbol_punctuation_tokenizer verification clean");
    end else begin
      $display("symbol_punctuation_tokenizer verification failed");
    end
    $finish;
  end

endmodule
